// File: src/thc_pkg.sv
// Package: shared types, constants and the microcode ROM of the compensation core.
`default_nettype none
package thc_pkg;

  typedef logic [19:0] raw_t;
  typedef logic [31:0] word_t;
  typedef logic [16:0] hum_t;
  typedef logic [5:0]  pc_t;
  typedef logic [3:0]  shamt_t;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_T1    = 4'd0,
    CFG_T2    = 4'd1,
    CFG_T3    = 4'd2,
    CFG_H1_H3 = 4'd3,
    CFG_H2    = 4'd4,
    CFG_H4    = 4'd5,
    CFG_H5    = 4'd6,
    CFG_H6    = 4'd7
  } cfg_idx_t;

  localparam logic CMD_TEMP = 1'b0;
  localparam logic CMD_HUM  = 1'b1;

  localparam word_t HumClampMax = 32'd419430400;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_ADD = 2'd1,
    ALU_SUB = 2'd2
  } alu_op_t;

  typedef enum logic [1:0] {
    DST_A = 2'd0,
    DST_B = 2'd1,
    DST_C = 2'd2,
    DST_D = 2'd3
  } dst_t;

  typedef enum logic [4:0] {
    OP_REG_A, OP_REG_B, OP_REG_C, OP_REG_D, OP_FINE,
    OP_RAW_S3, OP_RAW_S4, OP_T1_X2, OP_T1, OP_T2, OP_T3,
    OP_ADC_S14, OP_H4_X20, OP_H1, OP_H2, OP_H3, OP_H5, OP_H6,
    OP_K0, OP_K5, OP_K128, OP_K76800, OP_K16384, OP_K32768,
    OP_K2097152, OP_K8192
  } opnd_t;

  typedef struct packed {
    alu_op_t op;
    dst_t    dst;
    opnd_t   src_a;
    opnd_t   src_b;
    shamt_t  sh;
    logic    wr_fine;
    logic    last;
  } uop_t;

  localparam pc_t TempStart = 6'd0;
  localparam pc_t HumStart  = 6'd11;

  function automatic uop_t mk(input alu_op_t op, input dst_t dst, input opnd_t a,
                              input opnd_t b, input shamt_t sh, input logic wf,
                              input logic last);
    uop_t u;
    u.op      = op;
    u.dst     = dst;
    u.src_a   = a;
    u.src_b   = b;
    u.sh      = sh;
    u.wr_fine = wf;
    u.last    = last;
    return u;
  endfunction

  // Temperature program lives at 0..10, humidity program at 11..32.
  function automatic uop_t ucode(input pc_t pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(ALU_SUB, DST_A, OP_RAW_S3, OP_T1_X2,    4'd0,  1'b0, 1'b0);
      6'd1:  u = mk(ALU_MUL, DST_A, OP_REG_A,  OP_T2,       4'd0,  1'b0, 1'b0);
      6'd2:  u = mk(ALU_ADD, DST_A, OP_REG_A,  OP_K0,       4'd11, 1'b0, 1'b0);
      6'd3:  u = mk(ALU_SUB, DST_B, OP_RAW_S4, OP_T1,       4'd0,  1'b0, 1'b0);
      6'd4:  u = mk(ALU_MUL, DST_B, OP_REG_B,  OP_REG_B,    4'd0,  1'b0, 1'b0);
      6'd5:  u = mk(ALU_ADD, DST_B, OP_REG_B,  OP_K0,       4'd12, 1'b0, 1'b0);
      6'd6:  u = mk(ALU_MUL, DST_B, OP_REG_B,  OP_T3,       4'd0,  1'b0, 1'b0);
      6'd7:  u = mk(ALU_ADD, DST_B, OP_REG_B,  OP_K0,       4'd14, 1'b0, 1'b0);
      6'd8:  u = mk(ALU_ADD, DST_A, OP_REG_A,  OP_REG_B,    4'd0,  1'b1, 1'b0);
      6'd9:  u = mk(ALU_MUL, DST_A, OP_REG_A,  OP_K5,       4'd0,  1'b0, 1'b0);
      6'd10: u = mk(ALU_ADD, DST_A, OP_REG_A,  OP_K128,     4'd8,  1'b0, 1'b1);
      6'd11: u = mk(ALU_SUB, DST_C, OP_FINE,   OP_K76800,   4'd0,  1'b0, 1'b0);
      6'd12: u = mk(ALU_MUL, DST_A, OP_H5,     OP_REG_C,    4'd0,  1'b0, 1'b0);
      6'd13: u = mk(ALU_SUB, DST_A, OP_ADC_S14, OP_REG_A,   4'd0,  1'b0, 1'b0);
      6'd14: u = mk(ALU_SUB, DST_A, OP_REG_A,  OP_H4_X20,   4'd0,  1'b0, 1'b0);
      6'd15: u = mk(ALU_ADD, DST_A, OP_REG_A,  OP_K16384,   4'd15, 1'b0, 1'b0);
      6'd16: u = mk(ALU_MUL, DST_B, OP_REG_C,  OP_H6,       4'd0,  1'b0, 1'b0);
      6'd17: u = mk(ALU_ADD, DST_B, OP_REG_B,  OP_K0,       4'd10, 1'b0, 1'b0);
      6'd18: u = mk(ALU_MUL, DST_D, OP_REG_C,  OP_H3,       4'd0,  1'b0, 1'b0);
      6'd19: u = mk(ALU_ADD, DST_D, OP_REG_D,  OP_K0,       4'd11, 1'b0, 1'b0);
      6'd20: u = mk(ALU_ADD, DST_D, OP_REG_D,  OP_K32768,   4'd0,  1'b0, 1'b0);
      6'd21: u = mk(ALU_MUL, DST_B, OP_REG_B,  OP_REG_D,    4'd0,  1'b0, 1'b0);
      6'd22: u = mk(ALU_ADD, DST_B, OP_REG_B,  OP_K0,       4'd10, 1'b0, 1'b0);
      6'd23: u = mk(ALU_ADD, DST_B, OP_REG_B,  OP_K2097152, 4'd0,  1'b0, 1'b0);
      6'd24: u = mk(ALU_MUL, DST_B, OP_REG_B,  OP_H2,       4'd0,  1'b0, 1'b0);
      6'd25: u = mk(ALU_ADD, DST_B, OP_REG_B,  OP_K8192,    4'd14, 1'b0, 1'b0);
      6'd26: u = mk(ALU_MUL, DST_A, OP_REG_A,  OP_REG_B,    4'd0,  1'b0, 1'b0);
      6'd27: u = mk(ALU_ADD, DST_B, OP_REG_A,  OP_K0,       4'd15, 1'b0, 1'b0);
      6'd28: u = mk(ALU_MUL, DST_B, OP_REG_B,  OP_REG_B,    4'd0,  1'b0, 1'b0);
      6'd29: u = mk(ALU_ADD, DST_B, OP_REG_B,  OP_K0,       4'd7,  1'b0, 1'b0);
      6'd30: u = mk(ALU_MUL, DST_B, OP_REG_B,  OP_H1,       4'd0,  1'b0, 1'b0);
      6'd31: u = mk(ALU_ADD, DST_B, OP_REG_B,  OP_K0,       4'd4,  1'b0, 1'b0);
      6'd32: u = mk(ALU_SUB, DST_A, OP_REG_A,  OP_REG_B,    4'd0,  1'b0, 1'b1);
      default: u = mk(ALU_ADD, DST_D, OP_K0, OP_K0, 4'd0, 1'b0, 1'b1);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// File: src/thc_if.sv
// Interfaces: sample input channel and compensated result channel.
`default_nettype none
interface thc_in_if;
  logic            valid;
  logic            ready;
  logic            command;
  thc_pkg::raw_t   raw_sample;

  modport source (output valid, output command, output raw_sample, input ready);
  modport sink   (input valid, input command, input raw_sample, output ready);
endinterface

interface thc_out_if;
  logic            valid;
  logic            ready;
  logic            result_kind;
  thc_pkg::word_t  temperature_centi;
  thc_pkg::hum_t   humidity_q10;

  modport source (output valid, output result_kind, output temperature_centi,
                  output humidity_q10, input ready);
  modport sink   (input valid, input result_kind, input temperature_centi,
                  input humidity_q10, output ready);
endinterface
`default_nettype wire

// File: src/thc_alu.sv
// Shared arithmetic unit: 32-bit wrapping multiply, or add/subtract followed by an arithmetic shift.
`default_nettype none
module thc_alu (
  input  thc_pkg::alu_op_t op,
  input  thc_pkg::word_t   a,
  input  thc_pkg::word_t   b,
  input  thc_pkg::shamt_t  sh,
  output thc_pkg::word_t   y
);
  import thc_pkg::*;

  word_t prod;
  word_t sum;

  assign prod = a * b;
  assign sum  = (op == ALU_SUB) ? (a - b) : (a + b);

  always_comb begin
    case (op)
      ALU_MUL: y = prod;
      ALU_ADD, ALU_SUB: y = word_t'($signed(sum) >>> sh);
      default: y = prod;
    endcase
  end

endmodule
`default_nettype wire

// File: src/thc_seq.sv
// Sequencer: program counter that steps through the microcode of one sample.
`default_nettype none
module thc_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          cmd,
  input  logic          advance,
  output thc_pkg::uop_t uop
);
  import thc_pkg::*;

  pc_t pc_r;
  pc_t pc_nxt;

  always_comb begin
    pc_nxt = pc_r;
    if (start) begin
      pc_nxt = (cmd == CMD_HUM) ? HumStart : TempStart;
    end else if (advance && !uop.last) begin
      pc_nxt = pc_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= TempStart;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign uop = ucode(pc_r);

endmodule
`default_nettype wire

// File: src/temp_humidity_compensation_core.sv
// Top level: integer temperature and humidity compensation with a shared multiply/add unit.
//
//  Channel  Direction  Handshake             Contents
//  in_chan  input      valid/ready           command, raw_sample
//  out_chan output     valid/ready           result_kind, temperature_centi, humidity_q10
//  cfg_*    input      write enable only     cfg_index, cfg_wdata (calibration coefficients)
//
// A temperature word runs the temperature microcode program and a humidity word the
// humidity program once it is accepted; the multiply/add unit carries out one step per
// cycle, except that the last step holds while the output register cannot take it.
// Reset (synchronous, active low) clears the coefficients, the fine temperature, the
// sequencer and the result valid flag.
// in_chan.ready is high whenever no word is being worked on, even while the previous
// result still waits in the output register. A finished word whose result cannot be
// stored yet holds on its last step until out_chan.ready frees the output register.
`default_nettype none
module temp_humidity_compensation_core (
  input  logic                             clk,
  input  logic                             rst_n,
  thc_in_if.sink                           in_chan,
  thc_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [thc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [thc_pkg::CfgDataW-1:0]     cfg_wdata
);
  import thc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Calibration coefficients, stored at their natural widths.
  logic [15:0] cal_t1_r;
  logic [15:0] cal_t2_r;
  logic [15:0] cal_t3_r;
  logic [15:0] cal_h1_h3_r;
  logic [15:0] cal_h2_r;
  logic [11:0] cal_h4_r;
  logic [11:0] cal_h5_r;
  logic [7:0]  cal_h6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t1_r    <= '0;
      cal_t2_r    <= '0;
      cal_t3_r    <= '0;
      cal_h1_h3_r <= '0;
      cal_h2_r    <= '0;
      cal_h4_r    <= '0;
      cal_h5_r    <= '0;
      cal_h6_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_T1:    cal_t1_r    <= cfg_wdata;
        CFG_T2:    cal_t2_r    <= cfg_wdata;
        CFG_T3:    cal_t3_r    <= cfg_wdata;
        CFG_H1_H3: cal_h1_h3_r <= cfg_wdata;
        CFG_H2:    cal_h2_r    <= cfg_wdata;
        CFG_H4:    cal_h4_r    <= cfg_wdata[11:0];
        CFG_H5:    cal_h5_r    <= cfg_wdata[11:0];
        CFG_H6:    cal_h6_r    <= cfg_wdata[7:0];
        default: ; // indexes past the coefficient list are dropped
      endcase
    end
  end

  // Control state, the captured sample and the output register.
  state_t state_r;
  logic   cmd_r;
  raw_t   raw_r;
  logic   out_valid_r;
  logic   out_kind_r;
  word_t  out_temp_r;
  hum_t   out_hum_r;

  uop_t   uop;
  word_t  opa;
  word_t  opb;
  word_t  alu_y;
  logic   in_acc;
  logic   running;
  logic   out_load;
  logic   step_go;
  word_t  hum_clamped;

  assign running  = (state_r == ST_RUN);
  assign in_acc   = in_chan.valid && in_chan.ready;
  // The last step may only retire once the output register can take its result.
  assign out_load = running && uop.last && (!out_valid_r || out_chan.ready);
  assign step_go  = running && (!uop.last || out_load);

  assign in_chan.ready = (state_r == ST_IDLE);

  thc_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .cmd     (in_chan.command),
    .advance (step_go),
    .uop     (uop)
  );

  // Working registers of the shared unit, and the fine temperature kept across words.
  word_t reg_a_r;
  word_t reg_b_r;
  word_t reg_c_r;
  word_t reg_d_r;
  word_t fine_r;

  always_comb begin
    case (uop.src_a)
      OP_REG_A:    opa = reg_a_r;
      OP_REG_B:    opa = reg_b_r;
      OP_REG_C:    opa = reg_c_r;
      OP_REG_D:    opa = reg_d_r;
      OP_FINE:     opa = fine_r;
      OP_RAW_S3:   opa = {15'd0, raw_r[19:3]};
      OP_RAW_S4:   opa = {16'd0, raw_r[19:4]};
      OP_ADC_S14:  opa = {2'd0, raw_r[15:0], 14'd0};
      OP_H5:       opa = {{20{cal_h5_r[11]}}, cal_h5_r};
      default:     opa = 32'd0;
    endcase
  end

  always_comb begin
    case (uop.src_b)
      OP_REG_A:    opb = reg_a_r;
      OP_REG_B:    opb = reg_b_r;
      OP_REG_C:    opb = reg_c_r;
      OP_REG_D:    opb = reg_d_r;
      OP_T1_X2:    opb = {15'd0, cal_t1_r, 1'b0};
      OP_T1:       opb = {16'd0, cal_t1_r};
      OP_T2:       opb = {{16{cal_t2_r[15]}}, cal_t2_r};
      OP_T3:       opb = {{16{cal_t3_r[15]}}, cal_t3_r};
      OP_H4_X20:   opb = {cal_h4_r, 20'd0};
      OP_H1:       opb = {24'd0, cal_h1_h3_r[7:0]};
      OP_H2:       opb = {{16{cal_h2_r[15]}}, cal_h2_r};
      OP_H3:       opb = {24'd0, cal_h1_h3_r[15:8]};
      OP_H6:       opb = {{24{cal_h6_r[7]}}, cal_h6_r};
      OP_K5:       opb = 32'd5;
      OP_K128:     opb = 32'd128;
      OP_K76800:   opb = 32'd76800;
      OP_K16384:   opb = 32'd16384;
      OP_K32768:   opb = 32'd32768;
      OP_K2097152: opb = 32'd2097152;
      OP_K8192:    opb = 32'd8192;
      default:     opb = 32'd0;
    endcase
  end

  thc_alu u_alu (
    .op (uop.op),
    .a  (opa),
    .b  (opb),
    .sh (uop.sh),
    .y  (alu_y)
  );

  always_ff @(posedge clk) begin
    if (step_go) begin
      case (uop.dst)
        DST_A:   reg_a_r <= alu_y;
        DST_B:   reg_b_r <= alu_y;
        DST_C:   reg_c_r <= alu_y;
        DST_D:   reg_d_r <= alu_y;
        default: reg_a_r <= alu_y;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_r <= '0;
    end else if (step_go && uop.wr_fine) begin
      fine_r <= alu_y;
    end
  end

  // Humidity intermediate: negative becomes zero, large values saturate at 100 percent.
  always_comb begin
    if (alu_y[31]) begin
      hum_clamped = 32'd0;
    end else if (alu_y > HumClampMax) begin
      hum_clamped = HumClampMax;
    end else begin
      hum_clamped = alu_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_RUN;
            cmd_r   <= in_chan.command;
            raw_r   <= in_chan.raw_sample;
          end
        end
        ST_RUN: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= cmd_r;
        out_temp_r  <= (cmd_r == CMD_TEMP) ? alu_y : 32'd0;
        out_hum_r   <= (cmd_r == CMD_HUM) ? hum_clamped[28:12] : 17'd0;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.result_kind       = out_kind_r;
  assign out_chan.temperature_centi = out_temp_r;
  assign out_chan.humidity_q10      = out_hum_r;

  // A word accepted from the input always starts the sequencer on the next cycle.
  a_accept_runs : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> running)
    else $error("accepted word did not start the sequencer");

  // A result only appears at the end of a run.
  a_result_from_run : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(running))
    else $error("result appeared without a run");

  // Humidity never exceeds 100 percent in Q10.
  a_hum_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == CMD_HUM) |-> (out_hum_r <= 17'd102400))
    else $error("humidity result out of range");

  // The field that does not belong to the result kind is zero.
  a_unused_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == CMD_TEMP && out_hum_r == 17'd0) ||
                     (out_kind_r == CMD_HUM && out_temp_r == 32'd0)))
    else $error("unused result field is not zero");

  // The fine temperature changes only while a temperature word runs.
  a_fine_only_temp : assert property (@(posedge clk) disable iff (!rst_n)
    (fine_r != $past(fine_r)) |-> ($past(running) && $past(cmd_r) == CMD_TEMP))
    else $error("fine temperature changed outside a temperature run");

endmodule
`default_nettype wire
